/* sv/psrb_pkg.sv */
// Shared constants, codes and handshake types of the per-source request buffer.
package psrb_pkg;

	localparam int NUM_SLOTS    = 8;
	localparam int SLOT_DEPTH   = 16;
	localparam int SHARED_DEPTH = 64;

	localparam int SLOT_W  = $clog2(NUM_SLOTS);
	localparam int SPOS_W  = $clog2(SLOT_DEPTH);
	localparam int SLEN_W  = $clog2(SLOT_DEPTH + 1);
	localparam int SHPOS_W = $clog2(SHARED_DEPTH);
	localparam int REQ_AW  = SLOT_W + SPOS_W;

	// Fixed field widths of the request and response words.
	localparam int MODE_W   = 2;
	localparam int ID_W     = 8;
	localparam int TAG_W    = 16;
	localparam int SIDX_W   = 3;
	localparam int EIDX_W   = 6;
	localparam int STATUS_W = 3;
	localparam int QLEN_W   = 7;
	localparam int SCNT_W   = 4;
	localparam int POS_W    = EIDX_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_PER_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIVERT   = 1'b1;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FETCH  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STS_DONE     = 3'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] STS_DIVERTED = 3'd2;
	localparam logic [STATUS_W-1:0] STS_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] STS_BADIDX   = 3'd4;
	localparam logic [STATUS_W-1:0] STS_NOFETCH  = 3'd5;

	typedef enum logic [1:0] {
		ACT_RESULT = 2'd0,
		ACT_FETCH  = 2'd1,
		ACT_REMOVE = 2'd2
	} psrb_act_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic move_rd;
		logic move_wr;
		logic emit;
	} psrb_cmd_t;

	typedef struct packed {
		psrb_act_t act;
		logic      move_more;
		logic      out_free;
	} psrb_sts_t;

endpackage

/* sv/psrb_ctrl.sv */
// Controller state machine of the per-source request buffer.
module psrb_ctrl import psrb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  psrb_sts_t sts,
	output psrb_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_DECIDE  = 5'b00010,
		S_MOVE_RD = 5'b00100,
		S_MOVE_WR = 5'b01000,
		S_FINISH  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
				if (req_valid) begin
					state_nx = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_nx   = (sts.act == ACT_REMOVE) ? S_MOVE_RD : S_FINISH;
			end
			S_MOVE_RD: begin
				// Each step reads the entry behind the gap, then writes it one place down.
				if (sts.move_more) begin
					cmd.move_rd = 1'b1;
					state_nx    = S_MOVE_WR;
				end else begin
					state_nx = S_FINISH;
				end
			end
			S_MOVE_WR: begin
				cmd.move_wr = 1'b1;
				state_nx    = S_MOVE_RD;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

/* sv/psrb_dp.sv */
// Datapath of the per-source request buffer: queues, lengths, slot table and result register.
module psrb_dp import psrb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [MODE_W-1:0]     mode,
	input  logic [ID_W-1:0]       requestor_id,
	input  logic                  is_write,
	input  logic [TAG_W-1:0]      request_tag,
	input  logic [SIDX_W-1:0]     slot_index,
	input  logic [EIDX_W-1:0]     entry_index,
	input  psrb_cmd_t             cmd,
	output psrb_sts_t             sts,
	input  logic                  rsp_stall,
	output logic                  rsp_valid,
	output logic [STATUS_W-1:0]   status,
	output logic [TAG_W-1:0]      found_tag,
	output logic [QLEN_W-1:0]     queue_length,
	output logic [SCNT_W-1:0]     slot_count
);

	// Configuration.
	logic per_mode_q;
	logic divert_q;

	// Latched request word.
	logic [MODE_W-1:0] mode_q;
	logic [ID_W-1:0]   id_q;
	logic              wr_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SIDX_W-1:0] sidx_q;
	logic [EIDX_W-1:0] eidx_q;

	// Queue state.
	logic [ID_W-1:0]   owner_q [NUM_SLOTS];
	logic [SLEN_W-1:0] slen_q [NUM_SLOTS];
	logic [SCNT_W-1:0] slots_used_q;
	logic [QLEN_W-1:0] shlen_q;
	logic [TAG_W-1:0]  req_mem [NUM_SLOTS * SLOT_DEPTH];
	logic [TAG_W-1:0]  sh_mem [SHARED_DEPTH];
	logic [TAG_W-1:0]  req_rd_q;
	logic [TAG_W-1:0]  sh_rd_q;

	// Place of the last successful fetch.
	logic              rec_valid_q;
	logic              rec_kind_q;
	logic [SLOT_W-1:0] rec_slot_q;
	logic [POS_W-1:0]  rec_pos_q;

	// Pending result and compaction pointer.
	logic [STATUS_W-1:0] res_status_q;
	logic [QLEN_W-1:0]   res_len_q;
	logic                res_fetch_q;
	logic                res_kind_q;
	logic [POS_W-1:0]    mv_q;
	logic [POS_W-1:0]    mv_end_q;
	logic                mv_kind_q;
	logic [SLOT_W-1:0]   mv_slot_q;
	logic [POS_W-1:0]    mv_nx;

	// Response register.
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [TAG_W-1:0]    found_tag_q;
	logic [QLEN_W-1:0]   qlen_q;
	logic [SCNT_W-1:0]   scnt_q;

	// Decision logic.
	logic              hit;
	logic [SLOT_W-1:0] hit_slot;
	logic [SLOT_W-1:0] ins_slot;
	logic [SLEN_W-1:0] ins_len;
	logic [QLEN_W-1:0] fetch_len;
	logic [QLEN_W-1:0] rem_len;
	psrb_act_t         d_act;
	logic [STATUS_W-1:0] d_status;
	logic [QLEN_W-1:0] d_len;
	logic              d_req_we;
	logic              d_sh_we;
	logic              d_new_slot;

	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		// Walk downward so the lowest matching slot wins.
		for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
			if (SCNT_W'(s) < slots_used_q && owner_q[s] == id_q) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(s);
			end
		end
	end

	assign ins_slot  = hit ? hit_slot : slots_used_q[SLOT_W-1:0];
	assign ins_len   = hit ? slen_q[ins_slot] : '0;
	assign fetch_len = per_mode_q ? QLEN_W'(slen_q[sidx_q]) : shlen_q;
	assign rem_len   = rec_kind_q ? QLEN_W'(slen_q[rec_slot_q]) : shlen_q;
	assign mv_nx     = mv_q + POS_W'(1);

	always_comb begin
		d_act      = ACT_RESULT;
		d_status   = STS_BADIDX;
		d_len      = '0;
		d_req_we   = 1'b0;
		d_sh_we    = 1'b0;
		d_new_slot = 1'b0;
		case (mode_q)
			MODE_INSERT: begin
				if (divert_q && wr_q) begin
					d_status = STS_DIVERTED;
				end else if (per_mode_q) begin
					if (!hit && slots_used_q == SCNT_W'(NUM_SLOTS)) begin
						d_status = STS_FULL;
					end else if (ins_len == SLEN_W'(SLOT_DEPTH)) begin
						d_status = STS_FULL;
						d_len    = QLEN_W'(SLOT_DEPTH);
					end else begin
						d_status   = STS_DONE;
						d_len      = QLEN_W'(ins_len) + QLEN_W'(1);
						d_req_we   = 1'b1;
						d_new_slot = !hit;
					end
				end else if (shlen_q == QLEN_W'(SHARED_DEPTH)) begin
					d_status = STS_FULL;
					d_len    = QLEN_W'(SHARED_DEPTH);
				end else begin
					d_status = STS_DONE;
					d_len    = shlen_q + QLEN_W'(1);
					d_sh_we  = 1'b1;
				end
			end
			MODE_FETCH: begin
				if (per_mode_q && SCNT_W'(sidx_q) >= slots_used_q) begin
					d_status = STS_BADIDX;
				end else if (fetch_len == '0) begin
					d_status = STS_EMPTY;
				end else if (QLEN_W'(eidx_q) >= fetch_len) begin
					d_status = STS_BADIDX;
					d_len    = fetch_len;
				end else begin
					d_act    = ACT_FETCH;
					d_status = STS_DONE;
					d_len    = fetch_len;
				end
			end
			MODE_REMOVE: begin
				if (!rec_valid_q) begin
					d_status = STS_NOFETCH;
				end else if (QLEN_W'(rec_pos_q) >= rem_len) begin
					d_status = STS_BADIDX;
					d_len    = rem_len;
				end else begin
					d_act    = ACT_REMOVE;
					d_status = STS_DONE;
					d_len    = rem_len - QLEN_W'(1);
				end
			end
			default: begin
				d_status = STS_BADIDX;
			end
		endcase
	end

	assign sts.act       = d_act;
	assign sts.move_more = (mv_q != mv_end_q);
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_mode_q <= 1'b0;
			divert_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PER_MODE: per_mode_q <= cfg_data[0];
				CFG_DIVERT:   divert_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			id_q   <= requestor_id;
			wr_q   <= is_write;
			tag_q  <= request_tag;
			sidx_q <= slot_index;
			eidx_q <= entry_index;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && d_new_slot) begin
			owner_q[ins_slot] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used_q <= '0;
			shlen_q      <= '0;
			rec_valid_q  <= 1'b0;
			rec_kind_q   <= 1'b0;
			rec_slot_q   <= '0;
			rec_pos_q    <= '0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slen_q[s] <= '0;
			end
		end else if (cmd.decide) begin
			if (d_new_slot) begin
				slots_used_q <= slots_used_q + SCNT_W'(1);
			end
			if (d_req_we) begin
				slen_q[ins_slot] <= ins_len + SLEN_W'(1);
			end
			if (d_sh_we) begin
				shlen_q <= shlen_q + QLEN_W'(1);
			end
			if (d_act == ACT_FETCH) begin
				rec_valid_q <= 1'b1;
				rec_kind_q  <= per_mode_q;
				rec_slot_q  <= sidx_q;
				rec_pos_q   <= eidx_q;
			end
			// The length drops at once; the compaction that follows uses its own bound.
			if (d_act == ACT_REMOVE) begin
				if (rec_kind_q) begin
					slen_q[rec_slot_q] <= slen_q[rec_slot_q] - SLEN_W'(1);
				end else begin
					shlen_q <= shlen_q - QLEN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			res_status_q <= d_status;
			res_len_q    <= d_len;
			res_fetch_q  <= (d_act == ACT_FETCH);
			res_kind_q   <= per_mode_q;
			mv_q         <= rec_pos_q;
			mv_end_q     <= POS_W'(rem_len - QLEN_W'(1));
			mv_kind_q    <= rec_kind_q;
			mv_slot_q    <= rec_slot_q;
		end else if (cmd.move_wr) begin
			mv_q <= mv_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && d_req_we) begin
			req_mem[{ins_slot, ins_len[SPOS_W-1:0]}] <= tag_q;
		end else if (cmd.move_wr && mv_kind_q) begin
			req_mem[{mv_slot_q, mv_q[SPOS_W-1:0]}] <= req_rd_q;
		end
		if (cmd.decide && d_act == ACT_FETCH) begin
			req_rd_q <= req_mem[{sidx_q, eidx_q[SPOS_W-1:0]}];
		end else if (cmd.move_rd) begin
			req_rd_q <= req_mem[{mv_slot_q, mv_nx[SPOS_W-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && d_sh_we) begin
			sh_mem[shlen_q[SHPOS_W-1:0]] <= tag_q;
		end else if (cmd.move_wr && !mv_kind_q) begin
			sh_mem[mv_q[SHPOS_W-1:0]] <= sh_rd_q;
		end
		if (cmd.decide && d_act == ACT_FETCH) begin
			sh_rd_q <= sh_mem[eidx_q[SHPOS_W-1:0]];
		end else if (cmd.move_rd) begin
			sh_rd_q <= sh_mem[mv_nx[SHPOS_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q    <= res_status_q;
			found_tag_q <= res_fetch_q ? (res_kind_q ? req_rd_q : sh_rd_q) : '0;
			qlen_q      <= res_len_q;
			scnt_q      <= slots_used_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign found_tag    = found_tag_q;
	assign queue_length = qlen_q;
	assign slot_count   = scnt_q;

endmodule

/* sv/per_source_request_buffer.sv */
// Per-source request buffer: request channel in, one response word per request out.
// A request word (mode, requestor_id, is_write, request_tag, slot_index,
// entry_index) is taken when req_valid is high and req_stall is low. Every
// request word yields exactly one response word (status, found_tag,
// queue_length, slot_count), offered with rsp_valid and taken when rsp_stall
// is low. Requests are handled one at a time: req_stall stays high from the
// cycle after a request is taken until its response is in the output register.
// Insert, fetch and rejected requests go through a decide state and a finish
// state, which loads the output register. A remove that is done also compacts
// the queue between those two states through its single-ported entry memory,
// with a read step and a write step for each entry behind the removed one.
// While the receiver stalls, the response word holds; the block may take one
// more request and finishes it, but holds it until the output register frees.
// Reset clears the configuration, all queue lengths, the slot count and the
// fetch record; stored entries are not cleared, since only written places are read.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once
// and are meant to happen while no request is in flight.
module per_source_request_buffer import psrb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [MODE_W-1:0]     mode,
	input  logic [ID_W-1:0]       requestor_id,
	input  logic                  is_write,
	input  logic [TAG_W-1:0]      request_tag,
	input  logic [SIDX_W-1:0]     slot_index,
	input  logic [EIDX_W-1:0]     entry_index,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [TAG_W-1:0]      found_tag,
	output logic [QLEN_W-1:0]     queue_length,
	output logic [SCNT_W-1:0]     slot_count
);

	psrb_cmd_t cmd;
	psrb_sts_t sts;

	psrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	psrb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.requestor_id (requestor_id),
		.is_write     (is_write),
		.request_tag  (request_tag),
		.slot_index   (slot_index),
		.entry_index  (entry_index),
		.cmd          (cmd),
		.sts          (sts),
		.rsp_stall    (rsp_stall),
		.rsp_valid    (rsp_valid),
		.status       (status),
		.found_tag    (found_tag),
		.queue_length (queue_length),
		.slot_count   (slot_count)
	);

endmodule

/* sv/psrb_checker.sv */
// Port-level checks of the per-source request buffer and their binding.
module psrb_checker import psrb_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic [STATUS_W-1:0] status,
	input logic [TAG_W-1:0]    found_tag,
	input logic [QLEN_W-1:0]   queue_length,
	input logic [SCNT_W-1:0]   slot_count
);

	// Only one request is in flight, so taking one closes the request channel.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another one is in flight");

	a_tag_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STS_DONE |-> found_tag == '0)
		else $error("found_tag set on a response that is not done");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> slot_count <= SCNT_W'(NUM_SLOTS)
			&& queue_length <= QLEN_W'(SHARED_DEPTH))
		else $error("slot count or queue length out of range");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STS_DIVERTED || status == STS_EMPTY
			|| status == STS_NOFETCH) |-> queue_length == '0)
		else $error("nonzero queue length on a response that touches no queue");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(found_tag)
			&& $stable(queue_length) && $stable(slot_count))
		else $error("stalled response word changed");

endmodule

bind per_source_request_buffer psrb_checker u_psrb_checker (.*);
